FILE: hdl/mtf_pkg.sv
// Package for the move-to-front codec: list size, entry and index widths.
// No dependencies; every other file of the codec imports it.
package mtf_pkg;

  // number of entries in the recency list
  localparam int ALPHABET_SIZE = 256;

  // width of one list entry and of the byte fields
  localparam int ENTRY_W = 8;

  // width of a list position counter
  localparam int IDX_W = $clog2(ALPHABET_SIZE);

  // compare width that holds a byte and the list size itself
  localparam int CMP_W = ($clog2(ALPHABET_SIZE + 1) > ENTRY_W + 1) ?
                         $clog2(ALPHABET_SIZE + 1) : ENTRY_W + 1;

  // position of the tail cell
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ALPHABET_SIZE - 1);

endpackage

FILE: hdl/mtf_in_if.sv
// Input channel of the move-to-front codec: valid/ready plus one input item.
// Depends on mtf_pkg for the field widths.
interface mtf_in_if;
  import mtf_pkg::*;

  logic               valid;
  logic               ready;
  logic [ENTRY_W-1:0] value_in;
  logic               stream_start;

  modport source (output valid, output value_in, output stream_start, input ready);
  modport sink   (input valid, input value_in, input stream_start, output ready);

endinterface

FILE: hdl/mtf_out_if.sv
// Output channel of the move-to-front codec: valid/ready plus one result.
// Depends on mtf_pkg for the field width.
interface mtf_out_if;
  import mtf_pkg::*;

  logic               valid;
  logic               ready;
  logic [ENTRY_W-1:0] value_out;

  modport source (output valid, output value_out, input ready);
  modport sink   (input valid, input value_out, output ready);

endinterface

FILE: hdl/mtf_cell.sv
// One cell of the recency ring: a list entry that loads from its neighbor.
// Depends on mtf_pkg for the entry width.
module mtf_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [mtf_pkg::ENTRY_W-1:0] init_value,
  input  logic                       shift_en,
  input  logic [mtf_pkg::ENTRY_W-1:0] d,
  output logic [mtf_pkg::ENTRY_W-1:0] q
);
  import mtf_pkg::*;

  // reset puts the cell at its place in identity order
  always_ff @(posedge clk) begin
    if (rst) begin
      q <= init_value;
    end else if (shift_en) begin
      q <= d;
    end
  end

endmodule

FILE: hdl/move_to_front_codec.sv
// Top level of the byte move-to-front codec: control, ring of cells, output register.
// Depends on mtf_pkg, mtf_in_if, mtf_out_if and mtf_cell.
//
//  channel  | dir | handshake      | payload
//  ---------+-----+----------------+------------------------------
//  in_ch    | in  | valid / ready  | value_in[7:0], stream_start
//  out_ch   | out | valid / ready  | value_out[7:0]
//  cfg      | in  | cfg_we         | cfg_wdata (decode_mode)
//
// The list sits in a ring of ALPHABET_SIZE cells that rotates one place per
// cycle during a lap, past a single head compare. Encode takes a transfer in,
// one rewrite lap and an emit per byte; decode takes a transfer in, one read
// lap, one rewrite lap and an emit.
// Reset (rst, synchronous) loads identity order and clears decode_mode.
// One item is in work at a time; a finished result waits in the output
// register while the next item is taken, and a stalled output holds the
// ring until the result register frees.
module move_to_front_codec (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  mtf_in_if.sink    in_ch,
  mtf_out_if.source out_ch
);
  import mtf_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_MOVE = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]         state;
  logic               decode_mode;
  logic               out_valid;
  logic [ENTRY_W-1:0] value_out;
  logic [ENTRY_W-1:0] key;
  logic [ENTRY_W-1:0] carry;
  logic [ENTRY_W-1:0] result;
  logic               start;
  logic               active;
  logic [IDX_W-1:0]   k;

  logic [ENTRY_W-1:0] cell_q [ALPHABET_SIZE];
  logic [ENTRY_W-1:0] head;
  logic [ENTRY_W-1:0] tail_d;
  logic               shift_en;
  logic               accept;
  logic               in_range;
  logic               pos_hit;
  logic               hit;
  logic               emit_go;

  assign accept   = in_ch.valid && in_ch.ready;
  assign in_range = CMP_W'(in_ch.value_in) < CMP_W'(ALPHABET_SIZE);
  assign shift_en = (state == ST_SCAN) || (state == ST_MOVE);
  assign emit_go  = (state == ST_EMIT) && (!out_valid || out_ch.ready);

  // head entry; a new stream sees identity order
  assign head    = start ? ENTRY_W'(k) : cell_q[0];
  assign pos_hit = CMP_W'(k) == CMP_W'(key);
  assign hit     = decode_mode ? pos_hit : (head == key);

  // entry appended at the tail: carried entry while the move is open
  always_comb begin
    tail_d = head;
    if ((state == ST_MOVE) && active) begin
      tail_d = carry;
    end
  end

  // ring of cells, each loading from its neighbor on the tail side; the tail loads tail_d
  for (genvar i = 0; i < ALPHABET_SIZE; i++) begin : g_cell
    logic [ENTRY_W-1:0] cell_d;
    if (i == ALPHABET_SIZE - 1) begin : g_tail
      assign cell_d = tail_d;
    end else begin : g_body
      assign cell_d = cell_q[i+1];
    end
    mtf_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .init_value (ENTRY_W'(i)),
      .shift_en   (shift_en),
      .d          (cell_d),
      .q          (cell_q[i])
    );
  end

  // control: state, mode register, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      decode_mode <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        decode_mode <= cfg_wdata;
      end
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= (decode_mode && in_range) ? ST_SCAN : ST_MOVE;
          end
        end
        ST_SCAN: begin
          if (k == LAST_IDX) begin
            state <= ST_MOVE;
          end
        end
        ST_MOVE: begin
          if (k == LAST_IDX) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath: item registers, lap counter, result
  always_ff @(posedge clk) begin
    if (emit_go) begin
      value_out <= result;
    end
    case (state)
      ST_IDLE: begin
        if (accept) begin
          key    <= in_ch.value_in;
          start  <= in_ch.stream_start;
          carry  <= in_ch.value_in;
          result <= '0;
          active <= in_range;
          k      <= '0;
        end
      end
      ST_SCAN: begin
        // read lap: pick up the entry at the requested position
        if (pos_hit) begin
          carry  <= head;
          result <= head;
        end
        k <= (k == LAST_IDX) ? '0 : k + IDX_W'(1);
      end
      ST_MOVE: begin
        // rewrite lap: entries ahead of the hit move back one place
        if (active) begin
          if (hit) begin
            active <= 1'b0;
            if (!decode_mode) begin
              result <= ENTRY_W'(k);
            end
          end else begin
            carry <= head;
          end
        end
        k <= (k == LAST_IDX) ? '0 : k + IDX_W'(1);
      end
      default: begin
      end
    endcase
  end

  assign in_ch.ready      = (state == ST_IDLE);
  assign out_ch.valid     = out_valid;
  assign out_ch.value_out = value_out;

endmodule

FILE: hdl/mtf_checker.sv
// Port-level checks for the move-to-front codec, bound to the top level.
// Depends on mtf_pkg and move_to_front_codec.
module mtf_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [mtf_pkg::ENTRY_W-1:0] value_out
);
  import mtf_pkg::*;

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value_out))
    else $error("result dropped or changed while stalled");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer taken while an item is in work");

  // a result never shows in the cycle after its transfer
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too early");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind move_to_front_codec mtf_checker u_mtf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .value_out (out_ch.value_out)
);

FILE: tb/sv/mtf_tb_pkg.sv
// Testbench package for the move-to-front codec: recency-list tracker that predicts
// and checks each result. Depends on mtf_pkg for the list size and entry width.
`timescale 1ns / 100ps
package mtf_tb_pkg;
  import mtf_pkg::*;

  class mtf_tracker;
    logic [ENTRY_W-1:0] order [ALPHABET_SIZE];
    logic               decoding;
    logic [ENTRY_W-1:0] pending_codes [$];
    int unsigned        mismatches;

    function new();
      decoding   = 1'b0;
      mismatches = 0;
      restore_order();
    endfunction

    // identity order: entry i holds the low byte of i
    function void restore_order();
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
        order[i] = ENTRY_W'(i);
      end
    endfunction

    function void set_direction(logic dec);
      decoding = dec;
    endfunction

    // Transfer into the codec: work out its result and update the list.
    function void take_symbol(logic [ENTRY_W-1:0] sym, logic start);
      int                 pos;
      logic               hit;
      logic [ENTRY_W-1:0] code;
      logic [ENTRY_W-1:0] held;
      pos  = 0;
      hit  = 1'b0;
      code = '0;
      if (start) restore_order();
      if (decoding) begin
        // position beyond the list gives 0 and leaves the list alone
        if (int'(sym) < ALPHABET_SIZE) begin
          pos  = int'(sym);
          hit  = 1'b1;
          code = order[pos];
        end
      end else begin
        // first match wins; a missing byte gives 0
        for (int i = 0; i < ALPHABET_SIZE && !hit; i++) begin
          if (order[i] == sym) begin
            hit = 1'b1;
            pos = i;
          end
        end
        if (hit) code = ENTRY_W'(pos);
      end
      if (hit) begin
        held = order[pos];
        for (int i = pos; i > 0; i--) begin
          order[i] = order[i-1];
        end
        order[0] = held;
      end
      pending_codes = {pending_codes, code};
    endfunction

    // Transfer out of the codec: compare against the oldest prediction.
    function void match_output(logic [ENTRY_W-1:0] got);
      logic [ENTRY_W-1:0] want;
      if (pending_codes.size() == 0) begin
        if (mismatches < 10) $display("unexpected result: value_out %0d", got);
        mismatches++;
      end else begin
        want = pending_codes.pop_front();
        if (got !== want) begin
          if (mismatches < 10) begin
            $display("mismatch: value_out expected %0d got %0d (decode %0b)",
                     want, got, decoding);
          end
          mismatches++;
        end
      end
    endfunction

    function int outstanding();
      return pending_codes.size();
    endfunction
  endclass

endpackage

FILE: tb/sv/tb.sv
// Top-level testbench of move_to_front_codec: directed and random streams in both
// directions with random idling on both channels. Depends on mtf_pkg, the channel
// interfaces, mtf_tb_pkg and the codec RTL.
`timescale 1ns / 100ps
module tb;
  import mtf_pkg::*;
  import mtf_tb_pkg::*;

  // slowest item is a decode: one read lap plus one rewrite lap
  localparam int ITEM_CYCLES   = 2 * ALPHABET_SIZE + 2;
  localparam int SETTLE_CYCLES = ITEM_CYCLES + 8;
  localparam int STALL_LIMIT   = 10 * ITEM_CYCLES + 1000;
  localparam int RANDOM_ITEMS  = 330;

  localparam logic ENCODE = 1'b0;
  localparam logic DECODE = 1'b1;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic cfg_we    = 1'b0;
  logic cfg_wdata = 1'b0;

  mtf_in_if  in_ch ();
  mtf_out_if out_ch ();

  move_to_front_codec u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  mtf_tracker  tracker;
  int          snd_idle_pct = 27;
  int          rcv_idle_pct = 64;
  int unsigned quiet_cycles = 0;

  // {stream_start, value_in} for the directed part
  logic [ENTRY_W:0] enc_steps [10] = '{
    9'h100, 9'h0FF, 9'h0FF, 9'h000, 9'h080, 9'h07F, 9'h101, 9'h001, 9'h0AA, 9'h055
  };
  logic [ENTRY_W:0] dec_steps [10] = '{
    9'h100, 9'h0FF, 9'h0FF, 9'h000, 9'h001, 9'h080, 9'h17F, 9'h055, 9'h0AA, 9'h000
  };

  always #1 clk = ~clk;

  // receiver: random ready, check each transfer out
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) tracker.match_output(out_ch.value_out);
      out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("move_to_front_codec verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one transfer into the codec, with random idle cycles ahead of it
  task automatic push_symbol(input logic [ENTRY_W-1:0] sym, input logic start);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.value_in     <= sym;
    in_ch.stream_start <= start;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.take_symbol(sym, start);
  endtask

  // hold off the sender until every predicted result is out
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_direction(input logic dec);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= dec;
    @(posedge clk);
    tracker.set_direction(dec);
    cfg_we    <= 1'b0;
  endtask

  // Random streams: mostly a small working set so the list gets reordered,
  // some fully random bytes, occasional stream restarts.
  task automatic random_symbols(input logic dec, input int count);
    logic [ENTRY_W-1:0] sym;
    logic [ENTRY_W-1:0] base;
    logic               start;
    base = ENTRY_W'($urandom_range(255));
    for (int n = 0; n < count; n++) begin
      start = (n == 0) || ($urandom_range(63) == 0);
      if (start) base = ENTRY_W'($urandom_range(255));
      if ($urandom_range(9) < 3) begin
        sym = ENTRY_W'($urandom_range(255));
      end else if (dec) begin
        sym = ENTRY_W'($urandom_range(7));
      end else begin
        sym = base + ENTRY_W'($urandom_range(7));
      end
      // sender pause mid-stream until the codec is empty
      if (n == count / 2) wait_drained();
      push_symbol(sym, start);
    end
  endtask

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.value_in     = '0;
    in_ch.stream_start = 1'b0;
    tracker            = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, repeats and restarts in each direction
    set_direction(ENCODE);
    foreach (enc_steps[i]) push_symbol(enc_steps[i][ENTRY_W-1:0], enc_steps[i][ENTRY_W]);
    set_direction(DECODE);
    foreach (dec_steps[i]) push_symbol(dec_steps[i][ENTRY_W-1:0], dec_steps[i][ENTRY_W]);

    // random: sender-light idling, then receiver-light, then none
    for (int g = 0; g < 3; g++) begin
      case (g)
        0: begin
          snd_idle_pct = 27;
          rcv_idle_pct = 64;
        end
        1: begin
          snd_idle_pct = 64;
          rcv_idle_pct = 27;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      set_direction(ENCODE);
      random_symbols(ENCODE, RANDOM_ITEMS);
      set_direction(DECODE);
      random_symbols(DECODE, RANDOM_ITEMS);
    end

    wait_drained();
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("move_to_front_codec verification clean");
    end else begin
      $display("move_to_front_codec verification failed");
    end
    $finish;
  end

endmodule
